[sv/sparse_poly_horner_evaluate_unit_assert.svh]
`ifndef SPARSE_POLY_HORNER_EVALUATE_UNIT_ASSERT_SVH
`define SPARSE_POLY_HORNER_EVALUATE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPHE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define SPHE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/sphe_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sphe_pkg;

  localparam int DATA_W    = 32;
  localparam int EXP_W     = 8;
  localparam int Q_FRAC    = 16;
  localparam int MUL_STEPS = DATA_W;
  localparam int CNT_W     = $clog2(MUL_STEPS);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [EXP_W-1:0]  exp_t;

  localparam exp_t  MAX_EXPONENT = 8'd255;
  localparam data_t Q_ONE        = 32'h0001_0000;
  localparam data_t Q_MAX        = 32'h7FFF_FFFF;
  localparam data_t Q_MIN        = 32'h8000_0000;
  localparam data_t Q_ZERO       = 32'h0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW,
    ST_MUL_R,
    ST_SQR,
    ST_MUL_B,
    ST_MUL_ACC,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  start;
    data_t a;
    data_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    data_t value;
    logic  ovf;
  } mul_rsp_t;

  typedef struct packed {
    logic  valid;
    data_t value;
    logic  ovf;
  } emit_t;

endpackage

`default_nettype wire

[sv/sphe_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sphe_in_if;
  import sphe_pkg::*;
  logic  valid;
  logic  ready;
  data_t coefficient;
  exp_t  exponent;
  logic  last_term;

  modport source (output valid, coefficient, exponent, last_term, input ready);
  modport sink (input valid, coefficient, exponent, last_term, output ready);
endinterface

interface sphe_out_if;
  import sphe_pkg::*;
  logic  valid;
  logic  ready;
  data_t value;
  logic  overflow;

  modport source (output valid, value, overflow, input ready);
  modport sink (input valid, value, overflow, output ready);
endinterface

interface sphe_cfg_if;
  import sphe_pkg::*;
  logic  valid;
  logic  ready;
  data_t x_value;

  modport source (output valid, x_value, input ready);
  modport sink (input valid, x_value, output ready);
endinterface

`default_nettype wire

[sv/sparse_poly_horner_evaluate_unit.sv]
// Sparse polynomial evaluator, Horner's rule over exponent gaps, signed Q16.16.
// cfg_ch: write the evaluation point x (one register, reset 0) while no
//   polynomial is in flight; cfg_ch.ready is always high.
// in_ch: one term per transaction, exponents strictly descending, last_term
//   marks the end of a polynomial. An empty polynomial is one zero term.
// out_ch: one transaction per polynomial with the value and a sticky
//   overflow bit that is set if any product or sum saturated.
// Every multiply runs on one shared bit-serial multiplier, one multiplier bit
//   per cycle.
// A term with no exponent gap goes straight from idle to the add. A gap g
//   costs popcount(g) + floor(log2(g)) + 1 passes; the last term pays the
//   same again for its own exponent. A gap of 255 needs 16 passes; a last
//   term with gap and exponent both 127 needs 28 passes.
// One term is worked on at a time; in_ch.ready is high only when idle.
// The result sits in an output register; a stalled receiver holds it there
//   and the next polynomial runs up to its final emit before it waits.
// Reset (rst_n low, synchronous) clears x, the accumulator, the overflow
//   flag and any partly received polynomial.
`timescale 1ns / 1ps
`default_nettype none

module sparse_poly_horner_evaluate_unit (
  input wire         clk,
  input wire         rst_n,
  sphe_cfg_if.sink   cfg_ch,
  sphe_in_if.sink    in_ch,
  sphe_out_if.source out_ch
);
  import sphe_pkg::*;

  data_t    x_value_r;
  logic     out_valid_r;
  data_t    out_value_r;
  logic     out_ovf_r;
  logic     out_free;
  logic     in_ready;
  emit_t    emit;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_value_r <= Q_ZERO;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      x_value_r <= cfg_ch.x_value;
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_value_r <= emit.value;
      out_ovf_r   <= emit.ovf;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.value    = out_value_r;
  assign out_ch.overflow = out_ovf_r;
  assign in_ch.ready     = in_ready;

  sphe_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ready),
    .coefficient (in_ch.coefficient),
    .exponent    (in_ch.exponent),
    .last_term   (in_ch.last_term),
    .x_value     (x_value_r),
    .out_free    (out_free),
    .emit        (emit),
    .mul_req     (mul_req),
    .mul_rsp     (mul_rsp)
  );

  sphe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

endmodule

`default_nettype wire

[sv/sphe_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_poly_horner_evaluate_unit_assert.svh"

module sphe_mul (
  input  wire               clk,
  input  wire               rst_n,
  input  sphe_pkg::mul_req_t req,
  output sphe_pkg::mul_rsp_t rsp
);
  import sphe_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  data_t            a_r;
  logic [DATA_W:0]  hi_r;
  data_t            lo_r;

  logic [DATA_W:0]     a_ext;
  logic [DATA_W:0]     addend;
  logic [DATA_W:0]     sum;
  logic                last_step;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-Q_FRAC:0] prod_top;
  logic                prod_ovf;

  assign a_ext     = {a_r[DATA_W-1], a_r};
  assign last_step = (cnt_r == CNT_W'(MUL_STEPS - 1));

  // sign bit of the multiplier carries negative weight
  always_comb begin
    if (!lo_r[0]) begin
      addend = '0;
    end else if (last_step) begin
      addend = -a_ext;
    end else begin
      addend = a_ext;
    end
  end

  assign sum = hi_r + addend;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_step) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r  <= req.a;
      hi_r <= '0;
      lo_r <= req.b;
    end else if (busy_r) begin
      hi_r <= {sum[DATA_W], sum[DATA_W:1]};
      lo_r <= {sum[0], lo_r[DATA_W-1:1]};
    end
  end

  // floor of product over 2^16, then clip to 32 bits
  assign prod     = {hi_r[DATA_W-1:0], lo_r};
  assign prod_top = prod[2*DATA_W-1:DATA_W+Q_FRAC-1];
  assign prod_ovf = !((&prod_top) || (~|prod_top));

  always_comb begin
    rsp.done = done_r;
    rsp.ovf  = prod_ovf;
    if (prod_ovf) begin
      rsp.value = prod[2*DATA_W-1] ? Q_MIN : Q_MAX;
    end else begin
      rsp.value = prod[DATA_W+Q_FRAC-1:Q_FRAC];
    end
  end

  `SPHE_ASSERT_NOW(a_mul_no_restart, req.start, !busy_r, "multiply started while busy")
  `SPHE_ASSERT_NEXT(a_mul_finish, busy_r && last_step && !req.start, done_r && !busy_r, "multiply did not finish after last step")
  `SPHE_ASSERT_NOW(a_mul_done_idle, done_r, !busy_r, "done while still busy")

endmodule

`default_nettype wire

[sv/sphe_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "sparse_poly_horner_evaluate_unit_assert.svh"

module sphe_seq (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  sphe_pkg::data_t    coefficient,
  input  sphe_pkg::exp_t     exponent,
  input  wire                last_term,
  input  sphe_pkg::data_t    x_value,
  input  wire                out_free,
  output sphe_pkg::emit_t    emit,
  output sphe_pkg::mul_req_t mul_req,
  input  sphe_pkg::mul_rsp_t mul_rsp
);
  import sphe_pkg::*;

  state_t state_r;
  state_t state_nxt;

  data_t acc_r;
  exp_t  prev_r;
  logic  in_poly_r;
  logic  sat_r;
  data_t coef_r;
  exp_t  expo_r;
  logic  last_r;
  logic  final_r;
  exp_t  e_r;
  data_t r_r;
  data_t b_r;

  logic            accept;
  exp_t            expo_in;
  logic            has_gap;
  logic [DATA_W:0] add_sum;
  logic            add_ovf;
  data_t           add_val;
  logic            more_bits;

  assign accept    = in_valid && in_ready;
  assign expo_in   = (exponent > MAX_EXPONENT) ? MAX_EXPONENT : exponent;
  assign has_gap   = in_poly_r && (prev_r > expo_in);
  assign more_bits = (e_r[EXP_W-1:1] != '0);

  assign add_sum = {acc_r[DATA_W-1], acc_r} + {coef_r[DATA_W-1], coef_r};
  assign add_ovf = add_sum[DATA_W] ^ add_sum[DATA_W-1];
  assign add_val = add_ovf ? (add_sum[DATA_W] ? Q_MIN : Q_MAX) : add_sum[DATA_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = has_gap ? ST_POW : ST_ADD;
        end
      end
      ST_POW: begin
        state_nxt = e_r[0] ? ST_MUL_R : ST_SQR;
      end
      ST_MUL_R: begin
        if (mul_rsp.done) begin
          state_nxt = ST_SQR;
        end
      end
      ST_SQR: begin
        state_nxt = more_bits ? ST_MUL_B : ST_MUL_ACC;
      end
      ST_MUL_B: begin
        if (mul_rsp.done) begin
          state_nxt = ST_POW;
        end
      end
      ST_MUL_ACC: begin
        if (mul_rsp.done) begin
          state_nxt = final_r ? ST_EMIT : ST_ADD;
        end
      end
      ST_ADD: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (expo_r != '0) begin
          state_nxt = ST_POW;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = r_r;
    mul_req.b     = b_r;
    emit.valid    = 1'b0;
    emit.value    = acc_r;
    emit.ovf      = sat_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_POW: begin
        mul_req.start = e_r[0];
      end
      ST_SQR: begin
        mul_req.start = 1'b1;
        if (more_bits) begin
          mul_req.a = b_r;
        end else begin
          mul_req.a = acc_r;
          mul_req.b = r_r;
        end
      end
      ST_EMIT: begin
        emit.valid = out_free;
      end
      ST_MUL_R, ST_MUL_B, ST_MUL_ACC, ST_ADD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      acc_r     <= Q_ZERO;
      prev_r    <= '0;
      in_poly_r <= 1'b0;
      sat_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept && !in_poly_r) begin
            acc_r     <= Q_ZERO;
            sat_r     <= 1'b0;
            in_poly_r <= 1'b1;
          end
        end
        ST_MUL_R, ST_MUL_B: begin
          if (mul_rsp.done) begin
            sat_r <= sat_r | mul_rsp.ovf;
          end
        end
        ST_MUL_ACC: begin
          if (mul_rsp.done) begin
            acc_r <= mul_rsp.value;
            sat_r <= sat_r | mul_rsp.ovf;
          end
        end
        ST_ADD: begin
          acc_r  <= add_val;
          sat_r  <= sat_r | add_ovf;
          prev_r <= expo_r;
        end
        ST_EMIT: begin
          if (out_free) begin
            acc_r     <= Q_ZERO;
            prev_r    <= '0;
            in_poly_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // term payload and power working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          coef_r  <= coefficient;
          expo_r  <= expo_in;
          last_r  <= last_term;
          e_r     <= prev_r - expo_in;
          r_r     <= Q_ONE;
          b_r     <= x_value;
          final_r <= 1'b0;
        end
      end
      ST_MUL_R: begin
        if (mul_rsp.done) begin
          r_r <= mul_rsp.value;
        end
      end
      ST_SQR: begin
        e_r <= e_r >> 1;
      end
      ST_MUL_B: begin
        if (mul_rsp.done) begin
          b_r <= mul_rsp.value;
        end
      end
      ST_ADD: begin
        // final scaling by x to the last exponent
        e_r     <= expo_r;
        r_r     <= Q_ONE;
        b_r     <= x_value;
        final_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  `SPHE_ASSERT_NOW(a_seq_done_in_mul, mul_rsp.done, (state_r == ST_MUL_R) || (state_r == ST_MUL_B) || (state_r == ST_MUL_ACC), "multiply result outside a multiply state")
  `SPHE_ASSERT_NEXT(a_seq_emit_clears, (state_r == ST_EMIT) && out_free, (state_r == ST_IDLE) && !in_poly_r && (acc_r == Q_ZERO), "emit did not return to idle")
  `SPHE_ASSERT_NEXT(a_seq_first_term, accept && !in_poly_r, (state_r == ST_ADD) && !sat_r && in_poly_r, "first term did not start a clean polynomial")

endmodule

`default_nettype wire
